// ----- rtl/bpig_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpig_pkg
// shared flag bundle for the box pair iou / giou pipeline
// ----------------------------------------------------------------------------
package bpig_pkg;

  typedef struct packed {
    logic u_ok;   // union area positive
    logic e_ok;   // enclosing area positive
    logic epos;   // enclosing width and height both positive
    logic isat;   // intersection >= union, iou saturates
    logic esat;   // intersection >= enclosing area
  } flags_t;

endpackage

// ----- rtl/bpig_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpig_geom
// three stages: edge differences, area products, union and flags
// ----------------------------------------------------------------------------
module bpig_geom #(
  parameter int CW = 16,
  parameter int UW = 2 * (CW + 1) + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] a_left,
  input  logic signed [CW-1:0] a_top,
  input  logic signed [CW-1:0] a_right,
  input  logic signed [CW-1:0] a_bottom,
  input  logic signed [CW-1:0] b_left,
  input  logic signed [CW-1:0] b_top,
  input  logic signed [CW-1:0] b_right,
  input  logic signed [CW-1:0] b_bottom,
  output logic                 out_valid,
  output logic [UW-1:0]        inter,
  output logic [UW-1:0]        uni,
  output logic [UW-1:0]        encl,
  output bpig_pkg::flags_t     flags
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic [2:0] vld;

  // stage 1
  logic signed [DW-1:0] iw_raw, ih_raw;
  logic signed [DW-1:0] iw, ih, ew, eh, aw, ah, bw, bh;
  logic signed [CW-1:0] min_r, max_l, min_b, max_t, max_r, min_l, max_b, min_t;

  // stage 2
  logic signed [PW-1:0] p_inter, p_a, p_b, p_encl;
  logic                 epos2;

  always_comb begin
    min_r  = (a_right < b_right) ? a_right : b_right;
    max_l  = (a_left > b_left) ? a_left : b_left;
    min_b  = (a_bottom < b_bottom) ? a_bottom : b_bottom;
    max_t  = (a_top > b_top) ? a_top : b_top;
    max_r  = (a_right > b_right) ? a_right : b_right;
    min_l  = (a_left < b_left) ? a_left : b_left;
    max_b  = (a_bottom > b_bottom) ? a_bottom : b_bottom;
    min_t  = (a_top < b_top) ? a_top : b_top;
    iw_raw = DW'(min_r) - DW'(max_l);
    ih_raw = DW'(min_b) - DW'(max_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iw <= iw_raw[DW-1] ? '0 : iw_raw;
      ih <= ih_raw[DW-1] ? '0 : ih_raw;
      ew <= DW'(max_r) - DW'(min_l);
      eh <= DW'(max_b) - DW'(min_t);
      aw <= DW'(a_right) - DW'(a_left);
      ah <= DW'(a_bottom) - DW'(a_top);
      bw <= DW'(b_right) - DW'(b_left);
      bh <= DW'(b_bottom) - DW'(b_top);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_inter <= iw * ih;
      p_a     <= aw * ah;
      p_b     <= bw * bh;
      p_encl  <= ew * eh;
      epos2   <= (ew > 0) && (eh > 0);
    end
  end

  logic signed [UW-1:0] uni_s, inter_s, encl_s;

  always_comb begin
    inter_s = UW'(p_inter);
    encl_s  = UW'(p_encl);
    uni_s   = UW'(p_a) + UW'(p_b) - inter_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inter      <= inter_s;
      uni        <= uni_s;
      encl       <= encl_s;
      flags.u_ok <= uni_s > 0;
      flags.e_ok <= encl_s > 0;
      flags.epos <= epos2;
      flags.isat <= inter_s >= uni_s;
      flags.esat <= inter_s >= encl_s;
    end
  end

  assign out_valid = vld[2];

endmodule

// ----- rtl/bpig_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpig_div_step
// one restoring division step for both quotients, registered
// ----------------------------------------------------------------------------
module bpig_div_step #(
  parameter int UW = 36,
  parameter int SB = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [UW-1:0]    rem_u_in,
  input  logic [UW-1:0]    rem_e_in,
  input  logic [SB-1:0]    q_u_in,
  input  logic [SB-1:0]    q_e_in,
  input  logic [UW-1:0]    den_u_in,
  input  logic [UW-1:0]    den_e_in,
  input  bpig_pkg::flags_t flags_in,
  output logic             out_valid,
  output logic [UW-1:0]    rem_u,
  output logic [UW-1:0]    rem_e,
  output logic [SB-1:0]    q_u,
  output logic [SB-1:0]    q_e,
  output logic [UW-1:0]    den_u,
  output logic [UW-1:0]    den_e,
  output bpig_pkg::flags_t flags
);

  logic [UW:0]   sh_u, sh_e;
  logic          ge_u, ge_e;
  logic [UW-1:0] rem_u_next, rem_e_next;

  always_comb begin
    sh_u       = {rem_u_in, 1'b0};
    sh_e       = {rem_e_in, 1'b0};
    ge_u       = sh_u >= {1'b0, den_u_in};
    ge_e       = sh_e >= {1'b0, den_e_in};
    rem_u_next = ge_u ? UW'(sh_u - {1'b0, den_u_in}) : sh_u[UW-1:0];
    rem_e_next = ge_e ? UW'(sh_e - {1'b0, den_e_in}) : sh_e[UW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_u <= rem_u_next;
      rem_e <= rem_e_next;
      q_u   <= SB'({q_u_in, ge_u});
      q_e   <= SB'({q_e_in, ge_e});
      den_u <= den_u_in;
      den_e <= den_e_in;
      flags <= flags_in;
    end
  end

endmodule

// ----- rtl/box_pair_iou_giou_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_pair_iou_giou_top
// pipelined iou and rescaled giou of one box pair per cycle while m_axis is not stalled
//
//  channel  | dir | payload
//  s_axis   | in  | tdata: a_left a_top a_right a_bottom b_left b_top b_right b_bottom
//  m_axis   | out | tdata: iou_score giou_scaled enclose_positive degenerate
//
// one pair enters per cycle while m_axis is not stalled; the pipeline is made of the
// three geometry stages, one stage per quotient bit and an output stage.
// rst is synchronous and clears only the valid bits.
// a stall on m_axis freezes every stage at once; nothing is dropped.
// ----------------------------------------------------------------------------
module box_pair_iou_giou_top #(
  parameter int COORD_WIDTH = 16,
  parameter int SCORE_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // iou_score, giou_scaled, enclose_positive, degenerate
  output logic [((2*(SCORE_BITS+1)+2+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CW  = COORD_WIDTH;
  localparam int SB  = SCORE_BITS;
  localparam int UW  = 2 * (CW + 1) + 2;
  localparam int OW  = 2 * (SB + 1) + 2;
  localparam int OWP = ((OW + 7) / 8) * 8;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic             g_valid;
  logic [UW-1:0]    g_inter, g_uni, g_encl;
  bpig_pkg::flags_t g_flags;

  bpig_geom #(.CW(CW), .UW(UW)) u_geom (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .a_left   (s_axis_tdata[0*CW +: CW]),
    .a_top    (s_axis_tdata[1*CW +: CW]),
    .a_right  (s_axis_tdata[2*CW +: CW]),
    .a_bottom (s_axis_tdata[3*CW +: CW]),
    .b_left   (s_axis_tdata[4*CW +: CW]),
    .b_top    (s_axis_tdata[5*CW +: CW]),
    .b_right  (s_axis_tdata[6*CW +: CW]),
    .b_bottom (s_axis_tdata[7*CW +: CW]),
    .out_valid(g_valid),
    .inter    (g_inter),
    .uni      (g_uni),
    .encl     (g_encl),
    .flags    (g_flags)
  );

  logic             d_valid [SB+1];
  logic [UW-1:0]    d_rem_u [SB+1];
  logic [UW-1:0]    d_rem_e [SB+1];
  logic [SB-1:0]    d_q_u   [SB+1];
  logic [SB-1:0]    d_q_e   [SB+1];
  logic [UW-1:0]    d_den_u [SB+1];
  logic [UW-1:0]    d_den_e [SB+1];
  bpig_pkg::flags_t d_flags [SB+1];

  assign d_valid[0] = g_valid;
  assign d_rem_u[0] = g_inter;
  assign d_rem_e[0] = g_inter;
  assign d_q_u[0]   = '0;
  assign d_q_e[0]   = '0;
  assign d_den_u[0] = g_uni;
  assign d_den_e[0] = g_encl;
  assign d_flags[0] = g_flags;

  for (genvar i = 0; i < SB; i++) begin : g_div
    bpig_div_step #(.UW(UW), .SB(SB)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (d_valid[i]),
      .rem_u_in (d_rem_u[i]),
      .rem_e_in (d_rem_e[i]),
      .q_u_in   (d_q_u[i]),
      .q_e_in   (d_q_e[i]),
      .den_u_in (d_den_u[i]),
      .den_e_in (d_den_e[i]),
      .flags_in (d_flags[i]),
      .out_valid(d_valid[i+1]),
      .rem_u    (d_rem_u[i+1]),
      .rem_e    (d_rem_e[i+1]),
      .q_u      (d_q_u[i+1]),
      .q_e      (d_q_e[i+1]),
      .den_u    (d_den_u[i+1]),
      .den_e    (d_den_e[i+1]),
      .flags    (d_flags[i+1])
    );
  end

  localparam logic [SB:0] ONE = {1'b1, {SB{1'b0}}};

  bpig_pkg::flags_t fl;
  logic [SB:0]      iou, encq, giou;
  logic [SB+1:0]    gsum;
  logic             both_ok;

  always_comb begin
    fl      = d_flags[SB];
    both_ok = fl.u_ok && fl.e_ok;
    iou     = !fl.u_ok ? '0 : (fl.isat ? ONE : {1'b0, d_q_u[SB]});
    encq    = fl.esat ? ONE : {1'b0, d_q_e[SB]};
    gsum    = {1'b0, iou} + {1'b0, encq};
    giou    = both_ok ? gsum[SB+1:1] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= d_valid[SB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OWP'({!both_ok, fl.epos, giou, iou});
    end
  end

endmodule

// ----- tb/box_pair_iou_giou_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_pair_iou_giou_top_tb
// box pairs are driven through s_axis in bursts with gaps; every m_axis
// transfer is checked field by field against a local iou / giou predictor
// ----------------------------------------------------------------------------
module box_pair_iou_giou_top_tb;

  localparam int CW = 16;
  localparam int SB = 16;
  localparam int IW = ((8*CW+7)/8)*8;
  localparam int OW = ((2*(SB+1)+2+7)/8)*8;
  localparam int LATENCY = SB + 4;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic        degenerate;
    logic        enclose_positive;
    logic [16:0] giou_scaled;
    logic [16:0] iou_score;
  } score_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;

  box_pair_iou_giou_top #(.COORD_WIDTH(CW), .SCORE_BITS(SB)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  logic [IW-1:0] pair_queue[$];
  score_t        score_queue[$];
  int  mismatches = 0;
  int  checked = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  bit  hold_tx = 0;
  bit  in_taken = 0;
  int  burst_left = 0;
  int  gap_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic queue_pair(logic [IW-1:0] p);
    pair_queue = {pair_queue, p};
  endtask

  // floor(num * 2^SB / den) saturated to 1.0; num >= 0, den > 0
  function automatic logic [16:0] ratio_q(logic signed [63:0] num,
                                          logic signed [63:0] den);
    logic signed [127:0] q;
    if (num >= den) return 17'h10000;
    q = (128'(num) <<< SB) / 128'(den);
    return q[16:0];
  endfunction

  function automatic score_t score_pair(logic [IW-1:0] d);
    logic signed [31:0] al, at, ar, ab, bl, bt, br, bb, iw, ih, ew, eh;
    logic signed [63:0] inter, uni, encl;
    logic [16:0] iq, eq;
    score_t r;
    al = $signed(d[15:0]);    at = $signed(d[31:16]);
    ar = $signed(d[47:32]);   ab = $signed(d[63:48]);
    bl = $signed(d[79:64]);   bt = $signed(d[95:80]);
    br = $signed(d[111:96]);  bb = $signed(d[127:112]);
    iw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
    ih = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    ew = ((ar > br) ? ar : br) - ((al < bl) ? al : bl);
    eh = ((ab > bb) ? ab : bb) - ((at < bt) ? at : bt);
    inter = 64'(iw) * 64'(ih);
    uni = 64'(ar - al) * 64'(ab - at) + 64'(br - bl) * 64'(bb - bt) - inter;
    encl = 64'(ew) * 64'(eh);
    iq = '0;
    r.giou_scaled = '0;
    if (uni > 0) iq = ratio_q(inter, uni);
    if (uni > 0 && encl > 0) begin
      eq = ratio_q(inter, encl);
      r.giou_scaled = 17'((18'(iq) + 18'(eq)) >> 1);
    end
    r.iou_score = iq;
    r.enclose_positive = (ew > 0) && (eh > 0);
    r.degenerate = !((uni > 0) && (encl > 0));
    return r;
  endfunction

  function automatic logic [IW-1:0] pack_pair(int al, int at, int ar, int ab,
                                              int bl, int bt, int br, int bb);
    return {16'(bb), 16'(br), 16'(bt), 16'(bl), 16'(ab), 16'(ar), 16'(at), 16'(al)};
  endfunction

  function automatic int rnd_coord(bit wide_range);
    if (wide_range) return int'($signed(16'($urandom)));
    return $urandom_range(0, 4000) - 2000;
  endfunction

  // mostly well-formed overlapping boxes, some raw noise
  function automatic logic [IW-1:0] random_pair();
    int kind, al, at, w, h, bl, bt;
    kind = $urandom_range(0, 9);
    if (kind < 2) return {$urandom, $urandom, $urandom, $urandom};
    al = rnd_coord(kind == 2);
    at = rnd_coord(kind == 2);
    w = $urandom_range(0, 3000) - (kind == 3 ? 1500 : 0);
    h = $urandom_range(0, 3000) - (kind == 3 ? 1500 : 0);
    bl = al + $urandom_range(0, 2000) - 1000;
    bt = at + $urandom_range(0, 2000) - 1000;
    return pack_pair(al, at, al + w, at + h, bl, bt,
                     bl + $urandom_range(0, 3000), bt + $urandom_range(0, 3000));
  endfunction

  // driver: bursts with gaps; a new pair only once the last one was taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_taken) begin
        in_taken = 0;
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end
        if (gap_left > 0 && !hold_tx) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pair_queue.size() > 0 && !hold_tx) begin
          if (burst_left > 0) burst_left--;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pair_queue[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern plus one long hold-off
  int rx_phase = 0;
  always @(negedge clk) begin
    rx_phase++;
    if (hold_req) begin
      hold_req = 0;
      hold_left = 200;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end
    else if ((rx_phase / 64) % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0) && (rx_phase % 7 != 3);
  end

  // monitor
  always @(posedge clk) begin
    score_t got, want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        void'(pair_queue.pop_front());
        score_queue = {score_queue, score_pair(s_axis_tdata)};
        in_taken = 1;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = score_t'(m_axis_tdata[2*(SB+1)+1:0]);
        checked <= checked + 1;
        if (score_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result transfer %h", got);
        end else begin
          want = score_queue.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: iou %0d/%0d giou %0d/%0d epos %b/%b degen %b/%b",
                       want.iou_score, got.iou_score, want.giou_scaled,
                       got.giou_scaled, want.enclose_positive, got.enclose_positive,
                       want.degenerate, got.degenerate);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAIL box_pair_iou_giou_top");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: identical, disjoint, nested, inverted, zero size, extremes
    queue_pair(pack_pair(0, 0, 160, 160, 0, 0, 160, 160));
    queue_pair(pack_pair(0, 0, 16, 16, 32, 32, 48, 48));
    queue_pair(pack_pair(0, 0, 320, 320, 80, 80, 160, 160));
    queue_pair(pack_pair(0, 0, 100, 100, 50, 50, 150, 150));
    queue_pair(pack_pair(100, 100, 0, 0, 0, 0, 50, 50));
    queue_pair(pack_pair(100, 0, 0, 100, 200, 0, 150, 100));
    queue_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
    queue_pair(pack_pair(5, 5, 5, 5, 5, 5, 5, 5));
    queue_pair(pack_pair(0, 0, 0, 100, 0, 0, 0, 100));
    queue_pair(pack_pair(-32768, -32768, 32767, 32767,
                         -32768, -32768, 32767, 32767));
    queue_pair(pack_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
    queue_pair(pack_pair(32767, 32767, -32768, -32768,
                         32767, 32767, -32768, -32768));
    queue_pair(pack_pair(32767, -32768, -32768, 32767,
                         0, 0, 10, 10));
    queue_pair(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    queue_pair(pack_pair(0, 0, 10, 10, 10, 0, 20, 10));
    queue_pair(pack_pair(-32768, 0, -32767, 1, 32766, 0, 32767, 1));
    queue_pair(pack_pair(0, 0, 100, 100, 100, 100, 0, 0));
    wait (pair_queue.size() == 0);
    // sender pauses until every result is back
    hold_tx = 1;
    wait (score_queue.size() == 0 && !s_axis_tvalid);
    hold_tx = 0;
    for (n = 0; n < 200; n++) queue_pair(random_pair());
    // receiver holds off while the sender keeps offering
    hold_req = 1;
    wait (!hold_req);
    wait (hold_left == 0);
    for (n = 0; n < 200; n++) queue_pair(random_pair());
    wait (pair_queue.size() == 0);
    @(posedge clk);
    wait (score_queue.size() == 0);
    repeat (LATENCY * 2) @(posedge clk);
    $display("checked %0d result transfers from directed edge cases and random box pairs",
             checked);
    $display("covered back-pressure, input bursts and a full drain");
    if (mismatches == 0 && score_queue.size() == 0) begin
      $display("PASS box_pair_iou_giou_top");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL box_pair_iou_giou_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bpig_pkg.sv
rtl/bpig_geom.sv
rtl/bpig_div_step.sv
rtl/box_pair_iou_giou_top.sv
tb/box_pair_iou_giou_top_tb.sv
